// ===== hdl/lie_pkg.sv =====
// shared types and constants for the lagrange interpolation evaluator
package lie_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DUP = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // saturation bound of the wide internal values, 2^62 - 1
  localparam logic [63:0] WIDE_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DUP_RD  = 11'b000_0000_0010,
    S_DUP_CMP = 11'b000_0000_0100,
    S_EV_RD   = 11'b000_0000_1000,
    S_EV_LAT  = 11'b000_0001_0000,
    S_J_CHK   = 11'b000_0010_0000,
    S_J_LAT   = 11'b000_0100_0000,
    S_DIV     = 11'b000_1000_0000,
    S_MUL     = 11'b001_0000_0000,
    S_MUL_END = 11'b010_0000_0000,
    S_FIN     = 11'b100_0000_0000
  } state_t;

endpackage

// ===== hdl/lagrange_interpolation_eval_unit.sv =====
// lagrange interpolation evaluator: node table memories, shared divider and multiplier
// a load transaction completes at acceptance and gives no result
// evaluate with n nodes: a pairwise duplicate check, then for each node i one divide and
//   one multiply per factor (bit-serial divider, 4-step 32x32 multiplier) and a y*p multiply
// throughput: one evaluate at a time; loads are taken back to back while idle
// reset clears control state and sets node_count to 1; table contents stay undefined
module lagrange_interpolation_eval_unit #(
  parameter int MAX_NODES = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [3:0]         node_index,
  input  logic signed [31:0] node_x,
  input  logic signed [31:0] node_y,
  input  logic signed [31:0] query_x,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] interpolated_value,
  output logic [1:0]         status
);

  localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNW = $clog2(MAX_NODES + 1);
  localparam int NW  = 33 + FRAC_BITS;          // divider dividend width
  localparam int DCW = $clog2(NW + 1);

  lie_pkg::state_t state;

  logic [4:0]     node_count;
  logic [CNW-1:0] n_reg;
  logic [CNW-1:0] i_cnt;
  logic [CNW-1:0] j_cnt;

  // node tables: x has two read ports, y one
  logic [31:0] x_mem [MAX_NODES];
  logic [31:0] y_mem [MAX_NODES];
  logic [31:0] rd_xa;
  logic [31:0] rd_xb;
  logic [31:0] rd_y;

  logic [IW+3:0] idx_ext;
  logic          load_ok;
  logic          accept;

  // operands of the current evaluation
  logic signed [31:0] q_reg;
  logic [31:0]        xi_reg;
  logic [31:0]        yi_reg;
  logic [63:0]        p_mag;
  logic               p_neg;
  logic signed [63:0] acc;
  logic               sat_flag;

  // divider
  logic [NW-1:0]  dvd;
  logic [33:0]    rem;
  logic [32:0]    den_mag;
  logic           f_neg;
  logic [DCW-1:0] dcnt;
  logic [33:0]    trial;
  logic           qbit;

  // multiplier
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         m_neg;
  logic         m_term;         // product is a y*p term, else a factor step
  logic [2:0]   mcnt;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] prod;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [6:0]   sh_sel;

  // result staging
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  // combinational helpers
  logic [32:0]        num_w;
  logic [32:0]        den_w;
  logic [32:0]        num_m;
  logic [32:0]        den_m;
  logic               mul_sat;
  logic [61:0]        mul_r;
  logic signed [63:0] tres;
  logic signed [64:0] sum_w;
  logic signed [63:0] s_clamp;
  logic               s_sat;
  logic signed [31:0] fin_val;
  logic               fin_sat;
  logic [CNW-1:0]     n_eff;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == lie_pkg::S_IDLE);
  assign idx_ext  = (IW + 4)'(node_index);
  assign load_ok  = (32'(node_index) < 32'(MAX_NODES));

  // node count clamp to table depth
  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES)) begin
      n_eff = CNW'(MAX_NODES);
    end else begin
      n_eff = CNW'(node_count);
    end
  end

  // table memories, one write port, registered reads
  always_ff @(posedge clk) begin
    if (accept && operation == lie_pkg::OP_LOAD && load_ok) begin
      x_mem[idx_ext[IW-1:0]] <= node_x;
      y_mem[idx_ext[IW-1:0]] <= node_y;
    end
    rd_xa <= x_mem[i_cnt[IW-1:0]];
    rd_y  <= y_mem[i_cnt[IW-1:0]];
    rd_xb <= x_mem[j_cnt[IW-1:0]];
  end

  // differences for the factor (q - xj) / (xi - xj)
  always_comb begin
    num_w = {q_reg[31], q_reg} - {rd_xb[31], rd_xb};
    den_w = {xi_reg[31], xi_reg} - {rd_xb[31], rd_xb};
    num_m = num_w[32] ? (33'd0 - num_w) : num_w;
    den_m = den_w[32] ? (33'd0 - den_w) : den_w;
  end

  // one restoring division step
  always_comb begin
    trial = {rem[32:0], dvd[NW-1]};
    qbit  = (trial >= {1'b0, den_mag});
  end

  // partial product selection
  always_comb begin
    case (mcnt)
      3'd0: begin pa = ma[31:0];  pb = mb[31:0];  sh_sel = 7'd0;  end
      3'd1: begin pa = ma[31:0];  pb = mb[63:32]; sh_sel = 7'd32; end
      3'd2: begin pa = ma[63:32]; pb = mb[31:0];  sh_sel = 7'd32; end
      default: begin pa = ma[63:32]; pb = mb[63:32]; sh_sel = 7'd64; end
    endcase
  end

  // product scaling, saturation, term accumulation and final clamp
  always_comb begin
    mul_sat = |prod[127:62+FRAC_BITS];
    mul_r   = mul_sat ? lie_pkg::WIDE_CAP[61:0] : prod[FRAC_BITS+61:FRAC_BITS];
    tres    = m_neg ? -signed'({2'b00, mul_r}) : signed'({2'b00, mul_r});
    sum_w   = {acc[63], acc} + {tres[63], tres};
    s_sat   = 1'b0;
    if (sum_w > signed'({1'b0, lie_pkg::WIDE_CAP})) begin
      s_clamp = signed'(lie_pkg::WIDE_CAP);
      s_sat   = 1'b1;
    end else if (sum_w < -signed'({1'b0, lie_pkg::WIDE_CAP})) begin
      s_clamp = -signed'(lie_pkg::WIDE_CAP);
      s_sat   = 1'b1;
    end else begin
      s_clamp = sum_w[63:0];
    end
    fin_sat = 1'b0;
    if (s_clamp > 64'sh7FFF_FFFF) begin
      fin_val = 32'sh7FFF_FFFF;
      fin_sat = 1'b1;
    end else if (s_clamp < -64'sh8000_0000) begin
      fin_val = 32'sh8000_0000;
      fin_sat = 1'b1;
    end else begin
      fin_val = s_clamp[31:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lie_pkg::S_IDLE;
      node_count <= 5'd1;
      out_valid  <= 1'b0;
      i_cnt      <= '0;
      j_cnt      <= '0;
      n_reg      <= '0;
      mcnt       <= '0;
      dcnt       <= '0;
      sat_flag   <= 1'b0;
      m_term     <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      // the finish state reloads the output register itself
      if (out_valid && out_ready && state != lie_pkg::S_FIN) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        lie_pkg::S_IDLE: begin
          if (accept && operation == lie_pkg::OP_EVAL) begin
            q_reg      <= query_x;
            n_reg      <= n_eff;
            acc        <= '0;
            sat_flag   <= 1'b0;
            i_cnt      <= '0;
            j_cnt      <= CNW'(1);
            res_value  <= '0;
            res_status <= lie_pkg::STATUS_OK;
            if (n_eff == '0) begin
              state <= lie_pkg::S_FIN;
            end else if (n_eff == CNW'(1)) begin
              state <= lie_pkg::S_EV_RD;
            end else begin
              state <= lie_pkg::S_DUP_RD;
            end
          end
        end

        // pairwise check of used abscissas
        lie_pkg::S_DUP_RD: begin
          state <= lie_pkg::S_DUP_CMP;
        end

        lie_pkg::S_DUP_CMP: begin
          if (rd_xa == rd_xb) begin
            res_value  <= '0;
            res_status <= lie_pkg::STATUS_DUP;
            state      <= lie_pkg::S_FIN;
          end else if (j_cnt == n_reg - CNW'(1)) begin
            if (i_cnt == n_reg - CNW'(2)) begin
              i_cnt <= '0;
              state <= lie_pkg::S_EV_RD;
            end else begin
              i_cnt <= i_cnt + CNW'(1);
              j_cnt <= i_cnt + CNW'(2);
              state <= lie_pkg::S_DUP_RD;
            end
          end else begin
            j_cnt <= j_cnt + CNW'(1);
            state <= lie_pkg::S_DUP_RD;
          end
        end

        // fetch node i
        lie_pkg::S_EV_RD: begin
          state <= lie_pkg::S_EV_LAT;
        end

        lie_pkg::S_EV_LAT: begin
          xi_reg <= rd_xa;
          yi_reg <= rd_y;
          p_mag  <= 64'd1 << FRAC_BITS;
          p_neg  <= 1'b0;
          j_cnt  <= '0;
          state  <= lie_pkg::S_J_CHK;
        end

        // walk j, x[j] read issued here
        lie_pkg::S_J_CHK: begin
          if (j_cnt == n_reg) begin
            ma     <= yi_reg[31] ? (64'd0 - {{32{yi_reg[31]}}, yi_reg}) : {32'd0, yi_reg};
            mb     <= p_mag;
            m_neg  <= yi_reg[31] ^ p_neg;
            m_term <= 1'b1;
            mcnt   <= '0;
            prod   <= '0;
            state  <= lie_pkg::S_MUL;
          end else if (j_cnt == i_cnt) begin
            j_cnt <= j_cnt + CNW'(1);
          end else begin
            state <= lie_pkg::S_J_LAT;
          end
        end

        lie_pkg::S_J_LAT: begin
          dvd     <= NW'(num_m) << FRAC_BITS;
          den_mag <= den_m;
          f_neg   <= num_w[32] ^ den_w[32];
          rem     <= '0;
          dcnt    <= '0;
          state   <= lie_pkg::S_DIV;
        end

        // one quotient bit a cycle
        lie_pkg::S_DIV: begin
          rem  <= qbit ? (trial - {1'b0, den_mag}) : trial;
          dvd  <= {dvd[NW-2:0], qbit};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(NW - 1)) begin
            state <= lie_pkg::S_MUL;
          end
        end

        // four 32x32 partial products, each added in the cycle after it is formed
        lie_pkg::S_MUL: begin
          if (mcnt == '0 && !m_term) begin
            // first pass after the divider: load factor operands
            if (dcnt != '0) begin
              ma    <= p_mag;
              mb    <= 64'(dvd);
              m_neg <= p_neg ^ f_neg;
              prod  <= '0;
              dcnt  <= '0;
            end else begin
              pp    <= 64'(pa) * 64'(pb);
              pp_sh <= sh_sel;
              mcnt  <= mcnt + 3'd1;
            end
          end else begin
            if (mcnt != '0) begin
              prod <= prod + (128'(pp) << pp_sh);
            end
            if (mcnt == 3'd4) begin
              state <= lie_pkg::S_MUL_END;
            end else begin
              pp    <= 64'(pa) * 64'(pb);
              pp_sh <= sh_sel;
              mcnt  <= mcnt + 3'd1;
            end
          end
        end

        lie_pkg::S_MUL_END: begin
          mcnt <= '0;
          if (m_term) begin
            m_term <= 1'b0;
            acc    <= s_clamp;
            if (i_cnt == n_reg - CNW'(1)) begin
              res_value  <= fin_val;
              res_status <= (sat_flag || mul_sat || s_sat || fin_sat) ?
                            lie_pkg::STATUS_SAT : lie_pkg::STATUS_OK;
              state      <= lie_pkg::S_FIN;
            end else begin
              sat_flag <= sat_flag | mul_sat | s_sat;
              i_cnt    <= i_cnt + CNW'(1);
              state    <= lie_pkg::S_EV_RD;
            end
          end else begin
            sat_flag <= sat_flag | mul_sat;
            p_mag    <= {2'b00, mul_r};
            p_neg    <= m_neg;
            j_cnt    <= j_cnt + CNW'(1);
            state    <= lie_pkg::S_J_CHK;
          end
        end

        // hand the result to the output register once it is free
        lie_pkg::S_FIN: begin
          if (!out_valid || out_ready) begin
            interpolated_value <= res_value;
            status             <= res_status;
            out_valid          <= 1'b1;
            state              <= lie_pkg::S_IDLE;
          end
        end

        default: begin
          state <= lie_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
